// ===== rtl/ftem_pkg.sv =====
// Shared types and codes for the exact-match forwarding table.
// Used by ftem_cell and forwarding_table_exact_match.
package ftem_pkg;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_SET    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_FLUSH  = 2'd3
  } ftem_mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } ftem_status_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RESULT = 3'b100
  } ftem_state_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic hit;
    logic free;
  } ftem_tok_t;

  // update broadcast to every cell after a search, or on a flush
  typedef struct packed {
    logic flush;
    logic wr_hit;
    logic wr_free;
    logic clr_hit;
  } ftem_cmd_t;

endpackage

// ===== rtl/ftem_cell.sv =====
// One slot of the forwarding table: holds used bit, key and flow, marks itself
// while the search token passes, and applies the broadcast update. Uses ftem_pkg.
module ftem_cell #(
  parameter int ADDR_BITS = 32,
  parameter int FLOW_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ftem_pkg::ftem_tok_t  tok_in,
  input  logic [FLOW_BITS-1:0] flow_in,
  output ftem_pkg::ftem_tok_t  tok_out,
  output logic [FLOW_BITS-1:0] flow_out,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [FLOW_BITS-1:0] wr_flow,
  input  ftem_pkg::ftem_cmd_t  cmd
);
  import ftem_pkg::*;

  logic                 used;
  logic [ADDR_BITS-1:0] key;
  logic [FLOW_BITS-1:0] flow;
  logic                 mark_hit;
  logic                 mark_free;
  logic                 hit_here;
  logic                 free_here;
  logic                 do_wr_hit;
  logic                 do_wr_free;

  assign hit_here   = used && (key == addr);
  assign free_here  = !used;
  assign do_wr_hit  = cmd.wr_hit && mark_hit;
  assign do_wr_free = cmd.wr_free && mark_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= 1'b0;
      mark_hit  <= 1'b0;
      mark_free <= 1'b0;
      tok_out   <= '0;
    end else begin
      if (tok_in.valid) begin
        tok_out.valid <= 1'b1;
        tok_out.hit   <= tok_in.hit | hit_here;
        tok_out.free  <= tok_in.free | free_here;
        mark_hit      <= hit_here;
        mark_free     <= free_here && !tok_in.free;
      end else begin
        tok_out <= '0;
      end
      if (cmd.flush) begin
        used <= 1'b0;
      end else if (do_wr_free) begin
        used <= 1'b1;
      end else if (cmd.clr_hit && mark_hit) begin
        used <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    flow_out <= hit_here ? flow : flow_in;
    if (do_wr_hit || do_wr_free) begin
      flow <= wr_flow;
    end
    if (do_wr_free) begin
      key <= addr;
    end
  end

endmodule

// ===== rtl/forwarding_table_exact_match.sv =====
// Top level of the exact-match forwarding table: command control, default
// route and the chain of ftem_cell slots. Uses ftem_pkg and ftem_cell.
//
// One command is handled at a time. Lookup, set and delete of a nonzero
// address send a search token down the row of ENTRIES cells, one cell per
// cycle, before the result is registered. Commands on the default entry
// (address 0) and flush need no search and go straight to the result. The
// result stays on the output until it is transferred; no new command is taken
// before that.
module forwarding_table_exact_match #(
  parameter int ENTRIES   = 16,
  parameter int ADDR_BITS = 32,
  parameter int FLOW_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [1:0]           mode,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [FLOW_BITS-1:0] flow_id,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic                 flow_valid,
  output logic [FLOW_BITS-1:0] flow_out,
  output logic [1:0]           status
);
  import ftem_pkg::*;

  ftem_state_t          state;
  ftem_mode_t           req_mode;
  ftem_mode_t           op_mode;
  logic [ADDR_BITS-1:0] op_addr;
  logic [FLOW_BITS-1:0] op_flow;
  logic                 launch;
  ftem_cmd_t            cmd;
  logic                 default_present;
  logic [FLOW_BITS-1:0] default_flow;
  logic                 accept;

  ftem_tok_t            tok   [ENTRIES+1];
  logic [FLOW_BITS-1:0] flows [ENTRIES+1];
  ftem_tok_t            tok_end;

  assign req_mode  = ftem_mode_t'(mode);
  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_RESULT);
  assign accept    = req_valid && !req_stall;

  assign tok[0]   = '{valid: launch, hit: 1'b0, free: 1'b0};
  assign flows[0] = '0;
  assign tok_end  = tok[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ftem_cell #(
      .ADDR_BITS(ADDR_BITS),
      .FLOW_BITS(FLOW_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .flow_in (flows[i]),
      .tok_out (tok[i+1]),
      .flow_out(flows[i+1]),
      .addr    (op_addr),
      .wr_flow (op_flow),
      .cmd     (cmd)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      launch          <= 1'b0;
      cmd             <= '0;
      default_present <= 1'b0;
    end else begin
      launch <= 1'b0;
      cmd    <= '0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req_mode == MODE_FLUSH) begin
              cmd.flush       <= 1'b1;
              default_present <= 1'b0;
              state           <= S_RESULT;
            end else if (address == '0) begin
              if (req_mode == MODE_SET) begin
                default_present <= 1'b1;
              end else if (req_mode == MODE_DELETE) begin
                default_present <= 1'b0;
              end
              state <= S_RESULT;
            end else begin
              launch <= 1'b1;
              state  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (tok_end.valid) begin
            if (op_mode == MODE_SET) begin
              if (tok_end.hit) begin
                cmd.wr_hit <= 1'b1;
              end else if (tok_end.free) begin
                cmd.wr_free <= 1'b1;
              end
            end else if (op_mode == MODE_DELETE && tok_end.hit) begin
              cmd.clr_hit <= 1'b1;
            end
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!rsp_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode    <= req_mode;
      op_addr    <= address;
      op_flow    <= flow_id;
      flow_valid <= 1'b0;
      flow_out   <= '0;
      status     <= STATUS_OK;
      if (address == '0) begin
        case (req_mode)
          MODE_LOOKUP: begin
            flow_valid <= default_present;
            flow_out   <= default_present ? default_flow : '0;
          end
          MODE_SET:    default_flow <= flow_id;
          MODE_DELETE: begin
            if (!default_present) begin
              status <= STATUS_NOT_FOUND;
            end
          end
          default: ;
        endcase
      end
    end else if (state == S_SCAN && tok_end.valid) begin
      case (op_mode)
        MODE_LOOKUP: begin
          if (tok_end.hit) begin
            flow_valid <= 1'b1;
            flow_out   <= flows[ENTRIES];
          end else begin
            flow_valid <= default_present;
            flow_out   <= default_present ? default_flow : '0;
          end
        end
        MODE_SET: begin
          if (!tok_end.hit && !tok_end.free) begin
            status <= STATUS_FULL;
          end
        end
        MODE_DELETE: begin
          if (!tok_end.hit) begin
            status <= STATUS_NOT_FOUND;
          end
        end
        default: ;
      endcase
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one update broadcast at once");

  a_cmd_in_result: assert property (@(posedge clk) disable iff (rst)
    (cmd != '0) |-> (state == S_RESULT))
    else $error("update broadcast outside result state");

  a_end_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok_end.valid |-> (state == S_SCAN))
    else $error("search token left the chain outside a search");

  a_launch_scan: assert property (@(posedge clk) disable iff (rst)
    launch |-> (state == S_SCAN) && (op_addr != '0))
    else $error("search launched without a nonzero address");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for forwarding_table_exact_match: directed commands, then
// random lookup/set/delete/flush traffic, checked against a behavioral table.
// Depends on ftem_pkg and the forwarding_table_exact_match RTL.
module testbench;
  import ftem_pkg::*;

  localparam int ENTRIES   = 16;
  localparam int POOL_SIZE = 20;
  localparam int N_ROWS    = 25;
  localparam int N_RANDOM  = 1425;

  typedef struct {
    logic         fv;
    logic [15:0]  flow;
    ftem_status_t st;
  } fib_result_t;

  typedef struct {
    ftem_mode_t   m;
    logic [31:0]  a;
    logic [15:0]  f;
    int unsigned  reps;
    bit           typed;
    logic         fv;
    logic [15:0]  flow;
    ftem_status_t st;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid;
  logic        req_stall;
  logic [1:0]  mode;
  logic [31:0] address;
  logic [15:0] flow_id;
  logic        rsp_valid;
  logic        rsp_stall;
  logic        flow_valid;
  logic [15:0] flow_out;
  logic [1:0]  status;

  bit          fib_used [ENTRIES];
  logic [31:0] fib_key [ENTRIES];
  logic [15:0] fib_flow [ENTRIES];
  bit          dflt_present;
  logic [15:0] dflt_flow;

  fib_result_t pending_results[$];
  int          fail_count = 0;
  int          rsp_count = 0;
  int          n_cmds = 0;
  int          n_hits = 0;
  int          n_dflt_hits = 0;
  int          n_full = 0;
  int          n_missing = 0;
  int          n_flush = 0;
  bit          calm = 1'b0;
  logic [31:0] pool [POOL_SIZE];

  script_row_t script [N_ROWS] = '{
    '{MODE_LOOKUP, 32'h1234_5678, 16'h0000, 1, 1'b1, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_DELETE, 32'h0000_0000, 16'h0000, 1, 1'b1, 1'b0, 16'h0000, STATUS_NOT_FOUND},
    '{MODE_DELETE, 32'hFFFF_FFFF, 16'h0000, 1, 1'b1, 1'b0, 16'h0000, STATUS_NOT_FOUND},
    '{MODE_SET,    32'h0000_0000, 16'hFFFF, 1, 1'b1, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_LOOKUP, 32'h0000_0000, 16'h0000, 1, 1'b1, 1'b1, 16'hFFFF, STATUS_OK},
    '{MODE_SET,    32'hFFFF_FFFF, 16'h0000, 1, 1'b1, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1, 1'b1, 1'b1, 16'h0000, STATUS_OK},
    '{MODE_SET,    32'h0000_0001, 16'hA5A5, 1, 1'b1, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_SET,    32'h0000_0001, 16'h5A5A, 1, 1'b0, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_LOOKUP, 32'h0000_0001, 16'h0000, 1, 1'b0, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_DELETE, 32'hFFFF_FFFF, 16'h0000, 1, 1'b1, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1, 1'b1, 1'b1, 16'hFFFF, STATUS_OK},
    '{MODE_DELETE, 32'h0000_0000, 16'h0000, 1, 1'b1, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 1, 1'b1, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_LOOKUP, 32'h0000_0001, 16'h0000, 1, 1'b0, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_FLUSH,  32'h0000_0000, 16'h0000, 1, 1'b1, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_LOOKUP, 32'h0000_0001, 16'h0000, 1, 1'b1, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_SET,    32'h0000_0100, 16'h0010, ENTRIES, 1'b1, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_SET,    32'h0000_0200, 16'h7777, 1, 1'b1, 1'b0, 16'h0000, STATUS_FULL},
    '{MODE_SET,    32'h0000_0105, 16'hABCD, 1, 1'b0, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_DELETE, 32'h0000_0100, 16'h0000, 1, 1'b0, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_SET,    32'h0000_0200, 16'h7777, 1, 1'b0, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_LOOKUP, 32'h0000_0200, 16'h0000, 1, 1'b0, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_LOOKUP, 32'h0000_0000, 16'h0000, 1, 1'b1, 1'b0, 16'h0000, STATUS_OK},
    '{MODE_FLUSH,  32'hFFFF_FFFF, 16'hFFFF, 1, 1'b1, 1'b0, 16'h0000, STATUS_OK}
  };

  forwarding_table_exact_match #(
    .ENTRIES(ENTRIES),
    .ADDR_BITS(32),
    .FLOW_BITS(16)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .mode(mode),
    .address(address),
    .flow_id(flow_id),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .flow_valid(flow_valid),
    .flow_out(flow_out),
    .status(status)
  );

  always #5 clk = ~clk;

  function automatic fib_result_t fib_apply(ftem_mode_t m, logic [31:0] a, logic [15:0] f);
    fib_result_t r;
    int hit;
    int spare;
    r.fv = 1'b0;
    r.flow = 16'h0000;
    r.st = STATUS_OK;
    hit = -1;
    spare = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (fib_used[i] && fib_key[i] == a) hit = i;
      if (!fib_used[i]) spare = i;
    end
    n_cmds++;
    case (m)
      MODE_LOOKUP: begin
        if (a != 0 && hit >= 0) begin
          r.fv = 1'b1;
          r.flow = fib_flow[hit];
          n_hits++;
        end else if (dflt_present) begin
          r.fv = 1'b1;
          r.flow = dflt_flow;
          n_dflt_hits++;
        end
      end
      MODE_SET: begin
        if (a == 0) begin
          dflt_present = 1'b1;
          dflt_flow = f;
        end else begin
          if (hit < 0) hit = spare;
          if (hit < 0) begin
            r.st = STATUS_FULL;
            n_full++;
          end else begin
            fib_used[hit] = 1'b1;
            fib_key[hit] = a;
            fib_flow[hit] = f;
          end
        end
      end
      MODE_DELETE: begin
        if (a == 0) begin
          if (dflt_present) dflt_present = 1'b0;
          else r.st = STATUS_NOT_FOUND;
        end else if (hit >= 0) begin
          fib_used[hit] = 1'b0;
        end else begin
          r.st = STATUS_NOT_FOUND;
        end
        if (r.st == STATUS_NOT_FOUND) n_missing++;
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) fib_used[i] = 1'b0;
        dflt_present = 1'b0;
        n_flush++;
      end
    endcase
    return r;
  endfunction

  task automatic send_cmd(input ftem_mode_t m, input logic [31:0] a, input logic [15:0] f,
                          input bit typed, input fib_result_t given);
    fib_result_t guess;
    while (!calm && $urandom_range(99) < 26) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    mode <= m;
    address <= a;
    flow_id <= f;
    do @(posedge clk); while (req_stall);
    guess = fib_apply(m, a, f);
    pending_results.push_back(typed ? given : guess);
    @(negedge clk);
  endtask

  initial begin
    fib_result_t want;
    ftem_mode_t  m;
    logic [31:0] a;
    logic [15:0] f;
    int          set_pct;
    int          r;
    req_valid = 1'b0;
    mode = MODE_LOOKUP;
    address = 32'h0;
    flow_id = 16'h0;
    for (int i = 0; i < ENTRIES; i++) fib_used[i] = 1'b0;
    dflt_present = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = $urandom;
      if (pool[i] == 0) pool[i] = 32'h8000_0000;
    end
    pool[0] = 32'hFFFF_FFFF;
    pool[1] = 32'h0000_0001;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) begin
      for (int k = 0; k < script[i].reps; k++) begin
        want.fv = script[i].fv;
        want.flow = script[i].flow;
        want.st = script[i].st;
        send_cmd(script[i].m, script[i].a + k, script[i].f + k[15:0], script[i].typed, want);
      end
    end

    set_pct = 40;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) begin
        r = $urandom_range(2);
        set_pct = (r == 0) ? 15 : (r == 1) ? 40 : 65;
      end
      calm = (n >= 700 && n < 900);
      if (n == 1100) begin
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
      end
      r = $urandom_range(99);
      if (r < 2) m = MODE_FLUSH;
      else if (r < 2 + set_pct) m = MODE_SET;
      else if (r < 22 + set_pct) m = MODE_DELETE;
      else m = MODE_LOOKUP;
      r = $urandom_range(99);
      if (r < 8) a = 32'h0;
      else if (r < 85) a = pool[$urandom_range(POOL_SIZE - 1)];
      else a = $urandom;
      f = 16'($urandom_range(16'hFFFF));
      send_cmd(m, a, f, 1'b0, want);
    end
    req_valid <= 1'b0;
    calm = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * ENTRIES + 8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    $display("Ran %0d commands: %0d lookup hits, %0d default-route hits, %0d flushes,",
             n_cmds, n_hits, n_dflt_hits, n_flush);
    $display("  %0d table-full sets and %0d deletes of absent entries; %0d mismatches.",
             n_full, n_missing, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        hold--;
      end else if (!held && rsp_count >= 300) begin
        held = 1'b1;
        hold = 300;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !calm && ($urandom_range(99) < 26);
      end
    end
  end

  always @(posedge clk) begin
    fib_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_count++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: flow_valid=%0d flow_out=%h status=%0d",
               flow_valid, flow_out, status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (flow_valid !== want.fv) begin
          $error("flow_valid: expected %0d, actual %0d", want.fv, flow_valid);
          fail_count++;
        end
        if (flow_out !== want.flow) begin
          $error("flow_out: expected %h, actual %h", want.flow, flow_out);
          fail_count++;
        end
        if (status !== want.st) begin
          $error("status: expected %0d, actual %0d", want.st, status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
